// ===== rtl/ookpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ookpd_pkg
// shared types and constants for the ook pulse duration capture unit
// ----------------------------------------------------------------------------
package ookpd_pkg;

  localparam int TICK_W   = 25;
  localparam int MAXDUR_W = 15;
  localparam int DUR_W    = 16;
  localparam int IDX_W    = 11;
  localparam int CNT_OUT_W = 12;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [TICK_W-1:0]   TICK_SAT          = {TICK_W{1'b1}};
  localparam logic [MAXDUR_W-1:0] MAX_DURATION_RST  = 15'd32000;
  localparam logic [TICK_W-1:0]   SILENCE_LIMIT_RST = 25'd250000;
  localparam logic [TICK_W-1:0]   LISTEN_LIMIT_RST  = 25'd30000000;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_MAX_DURATION  = 2'd0;
  localparam logic [1:0] REG_SILENCE_LIMIT = 2'd1;
  localparam logic [1:0] REG_LISTEN_LIMIT  = 2'd2;

  // input word function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [1:0] {
    END_FULL    = 2'd0,
    END_SILENCE = 2'd1,
    END_LISTEN  = 2'd2,
    END_ABORT   = 2'd3
  } end_reason_t;

  typedef struct packed {
    logic [MAXDUR_W-1:0] max_duration;
    logic [TICK_W-1:0]   silence_limit;
    logic [TICK_W-1:0]   listen_limit;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic level;
    logic abort_btn;
  } item_t;

  typedef struct packed {
    logic                    sample_valid;
    logic signed [DUR_W-1:0] duration;
    logic [IDX_W-1:0]        sample_index;
    logic                    ended;
    end_reason_t             end_reason;
    logic [CNT_OUT_W-1:0]    sample_count;
    logic                    got_signal;
  } result_t;

endpackage

// ===== rtl/ookpd_cfg.sv =====
// ----------------------------------------------------------------------------
// ookpd_cfg
// apb-style register file: cap and the two end-of-capture limits
// ----------------------------------------------------------------------------
module ookpd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ookpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ookpd_pkg::DATA_W-1:0]  pwdata,
  output logic [ookpd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output ookpd_pkg::cfg_t               cfg
);
  import ookpd_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_duration  <= MAX_DURATION_RST;
      cfg_r.silence_limit <= SILENCE_LIMIT_RST;
      cfg_r.listen_limit  <= LISTEN_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_DURATION:  cfg_r.max_duration  <= pwdata[MAXDUR_W-1:0];
        REG_SILENCE_LIMIT: cfg_r.silence_limit <= pwdata[TICK_W-1:0];
        REG_LISTEN_LIMIT:  cfg_r.listen_limit  <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_DURATION:  prdata = {{(DATA_W-MAXDUR_W){1'b0}}, cfg_r.max_duration};
      REG_SILENCE_LIMIT: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_r.silence_limit};
      REG_LISTEN_LIMIT:  prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_r.listen_limit};
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ookpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// ookpd_in_stage
// input register holding one word until the core takes it
// ----------------------------------------------------------------------------
module ookpd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ookpd_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output ookpd_pkg::item_t item
);
  import ookpd_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/ookpd_core.sv =====
// ----------------------------------------------------------------------------
// ookpd_core
// capture state, per-word update and the result register
// ----------------------------------------------------------------------------
module ookpd_core #(
  parameter int BUF_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ookpd_pkg::cfg_t    cfg,
  input  logic               item_valid,
  input  ookpd_pkg::item_t   item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output ookpd_pkg::result_t res
);
  import ookpd_pkg::*;

  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  // capture state
  logic              capturing_r, capturing_nxt;
  logic              last_level_r, last_level_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              edge_seen_r, edge_seen_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;

  logic              tick_act;
  logic              lvl_change;
  logic [TICK_W-1:0] ticks_inc;
  logic [MAXDUR_W-1:0] dur_cap;
  logic [DUR_W-1:0]  dur_mag;
  logic              is_full, is_silent, is_listen_out, end_now;
  logic [31:0]       idx_ext, cnt_ext;

  assign take = item_valid && (!out_valid_r || !out_stall);

  always_comb begin
    tick_act  = take && (item.func == FUNC_TICK) && capturing_r;
    ticks_inc = (ticks_r == TICK_SAT) ? ticks_r : ticks_r + 1'b1;
    lvl_change = item.level != last_level_r;

    if (ticks_inc > {{(TICK_W-MAXDUR_W){1'b0}}, cfg.max_duration}) begin
      dur_cap = cfg.max_duration;
    end else begin
      dur_cap = ticks_inc[MAXDUR_W-1:0];
    end
    dur_mag = {1'b0, dur_cap};

    capturing_nxt  = capturing_r;
    last_level_nxt = last_level_r;
    ticks_nxt      = ticks_r;
    edge_seen_nxt  = edge_seen_r;
    count_nxt      = count_r;

    if (take && item.func == FUNC_START) begin
      capturing_nxt  = 1'b1;
      last_level_nxt = item.level;
      ticks_nxt      = '0;
      edge_seen_nxt  = 1'b0;
      count_nxt      = '0;
    end else if (tick_act) begin
      ticks_nxt = ticks_inc;
      if (lvl_change) begin
        count_nxt      = count_r + 1'b1;
        ticks_nxt      = '0;
        last_level_nxt = item.level;
        edge_seen_nxt  = 1'b1;
      end
    end

    // end checks in priority order: full, silence, listen, abort
    is_full       = count_nxt >= CNT_W'(BUF_DEPTH);
    is_silent     = edge_seen_nxt && (ticks_nxt > cfg.silence_limit);
    is_listen_out = !edge_seen_nxt && (ticks_nxt > cfg.listen_limit);
    end_now       = is_full || is_silent || is_listen_out || item.abort_btn;

    if (tick_act && end_now) begin
      capturing_nxt = 1'b0;
    end

    idx_ext = 32'(count_r);
    cnt_ext = 32'(count_nxt);

    res_nxt.sample_valid = lvl_change;
    res_nxt.duration     = lvl_change ?
                           (last_level_r ? dur_mag : (16'd0 - dur_mag)) : '0;
    res_nxt.sample_index = lvl_change ? idx_ext[IDX_W-1:0] : '0;
    res_nxt.ended        = end_now;
    if (is_full) begin
      res_nxt.end_reason = END_FULL;
    end else if (is_silent) begin
      res_nxt.end_reason = END_SILENCE;
    end else if (is_listen_out) begin
      res_nxt.end_reason = END_LISTEN;
    end else if (item.abort_btn) begin
      res_nxt.end_reason = END_ABORT;
    end else begin
      res_nxt.end_reason = END_FULL;
    end
    res_nxt.sample_count = cnt_ext[CNT_OUT_W-1:0];
    res_nxt.got_signal   = count_nxt != '0;

    // a word leaves only for an edge or an end of capture
    if (take) begin
      out_valid_nxt = tick_act && (lvl_change || end_now);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r  <= 1'b0;
      last_level_r <= 1'b0;
      ticks_r      <= '0;
      edge_seen_r  <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      capturing_r  <= capturing_nxt;
      last_level_r <= last_level_nxt;
      ticks_r      <= ticks_nxt;
      edge_seen_r  <= edge_seen_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/ook_pulse_duration_capture_unit.sv =====
// ----------------------------------------------------------------------------
// ook_pulse_duration_capture_unit
// raw ook pulse width capture: turns start and microsecond tick words into
// signed pulse durations and an end-of-capture report
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+--------------------------------
//  in_*      | input     | in_valid/in_stall  | func, level, abort
//  out_*     | output    | out_valid/out_stall| sample_valid, duration, index,
//            |           |                    | ended, end_reason, count, got
//  apb       | input     | psel/penable       | max_duration, silence_limit,
//            |           |                    | listen_limit at 0x0/0x4/0x8
//
//  one word is taken every cycle unless the result register is full and stalled;
//  a word waits in the input register until taken, and its result is written to
//  the result register (out_valid rises in the cycle after the take if it yields a result)
//  the per-word update is a 25-bit saturating increment and four compares,
//  all between the input register and the result register
//  rst_n (synchronous) clears capture state and both stage valids and
//  restores the register defaults; no clearing pass is needed
//  out_stall holds the result register; the input register still takes the
//  next word and waits, so in_stall rises only when both stages are full
//
module ook_pulse_duration_capture_unit #(
  parameter int BUF_DEPTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic                                  in_level,
  input  logic                                  in_abort,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_sample_valid,
  output logic signed [ookpd_pkg::DUR_W-1:0]    out_duration,
  output logic [ookpd_pkg::IDX_W-1:0]           out_sample_index,
  output logic                                  out_ended,
  output logic [1:0]                            out_end_reason,
  output logic [ookpd_pkg::CNT_OUT_W-1:0]       out_sample_count,
  output logic                                  out_got_signal,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ookpd_pkg::ADDR_W-1:0]          paddr,
  input  logic [ookpd_pkg::DATA_W-1:0]          pwdata,
  output logic [ookpd_pkg::DATA_W-1:0]          prdata,
  output logic                                  pready
);
  import ookpd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t res;

  assign in_item.func      = in_func;
  assign in_item.level     = in_level;
  assign in_item.abort_btn = in_abort;

  // register file
  ookpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  ookpd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // capture state machine step and result register
  ookpd_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_sample_valid = res.sample_valid;
  assign out_duration     = res.duration;
  assign out_sample_index = res.sample_index;
  assign out_ended        = res.ended;
  assign out_end_reason   = res.end_reason;
  assign out_sample_count = res.sample_count;
  assign out_got_signal   = res.got_signal;

  // a word goes out only for an edge or an end of capture
  a_word_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_valid || out_ended))
    else $error("result word with neither sample nor end");

  // no sample means duration and index are zero
  a_empty_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_valid) |-> (out_duration == '0 && out_sample_index == '0))
    else $error("nonzero duration or index without a sample");

  // a sample implies the capture has signal
  a_sample_got_signal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sample_valid) |-> out_got_signal)
    else $error("sample reported without got_signal");

  // end reason stays zero while capture continues
  a_reason_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ended) |-> (out_end_reason == END_FULL))
    else $error("end reason set without end of capture");

endmodule
